### rtl/rieu_pkg.sv
// package: item types and instruction, fault and memory request codes
package rieu_pkg;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] pc;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [4:0]  reg_index;
    logic [31:0] write_value;
    logic [31:0] next_pc;
    logic [1:0]  mem_kind;
    logic [1:0]  mem_size;
    logic [31:0] mem_addr;
    logic [31:0] store_data;
    logic [1:0]  fault;
  } out_item_t;

  // fault codes
  localparam logic [1:0] FaultOk      = 2'd0;
  localparam logic [1:0] FaultPc      = 2'd1;
  localparam logic [1:0] FaultUnimp   = 2'd2;
  localparam logic [1:0] FaultUnknown = 2'd3;

  // memory request kind
  localparam logic [1:0] MemNone  = 2'd0;
  localparam logic [1:0] MemLoad  = 2'd1;
  localparam logic [1:0] MemStore = 2'd2;

  // memory request size
  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeHalf = 2'd1;
  localparam logic [1:0] SizeWord = 2'd2;

  // primary opcodes
  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpJ       = 6'h02;
  localparam logic [5:0] OpJal     = 6'h03;
  localparam logic [5:0] OpBeq     = 6'h04;
  localparam logic [5:0] OpBne     = 6'h05;
  localparam logic [5:0] OpAddi    = 6'h08;
  localparam logic [5:0] OpAddiu   = 6'h09;
  localparam logic [5:0] OpSlti    = 6'h0a;
  localparam logic [5:0] OpSltiu   = 6'h0b;
  localparam logic [5:0] OpAndi    = 6'h0c;
  localparam logic [5:0] OpOri     = 6'h0d;
  localparam logic [5:0] OpLui     = 6'h0f;
  localparam logic [5:0] OpCop0    = 6'h10;
  localparam logic [5:0] OpCop1    = 6'h11;
  localparam logic [5:0] OpLw      = 6'h23;
  localparam logic [5:0] OpLbu     = 6'h24;
  localparam logic [5:0] OpLhu     = 6'h25;
  localparam logic [5:0] OpSb      = 6'h28;
  localparam logic [5:0] OpSh      = 6'h29;
  localparam logic [5:0] OpSw      = 6'h2b;
  localparam logic [5:0] OpLl      = 6'h30;
  localparam logic [5:0] OpLd      = 6'h37;

  // function codes of special opcode
  localparam logic [5:0] FnSll   = 6'h00;
  localparam logic [5:0] FnSrl   = 6'h02;
  localparam logic [5:0] FnSra   = 6'h03;
  localparam logic [5:0] FnJr    = 6'h08;
  localparam logic [5:0] FnMfhi  = 6'h10;
  localparam logic [5:0] FnMflo  = 6'h12;
  localparam logic [5:0] FnMult  = 6'h18;
  localparam logic [5:0] FnDiv   = 6'h1a;
  localparam logic [5:0] FnDivu  = 6'h1b;
  localparam logic [5:0] FnAdd   = 6'h20;
  localparam logic [5:0] FnAddu  = 6'h21;
  localparam logic [5:0] FnSub   = 6'h22;
  localparam logic [5:0] FnSubu  = 6'h23;
  localparam logic [5:0] FnAnd   = 6'h24;
  localparam logic [5:0] FnOr    = 6'h25;
  localparam logic [5:0] FnNor   = 6'h27;
  localparam logic [5:0] FnSlt   = 6'h2a;
  localparam logic [5:0] FnSltu  = 6'h2b;

endpackage

### rtl/rieu_exec.sv
// decode and alu: turns one registered instruction into one result item
module rieu_exec
  import rieu_pkg::*;
(
  input  in_item_t  item_i,
  output out_item_t result_o
);

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  sh;
  logic [4:0]  rd_idx;
  logic [4:0]  rt_idx;
  logic [15:0] imm;
  logic [31:0] zimm;
  logic [31:0] simm;
  logic [31:0] rs;
  logic [31:0] rt;
  logic [31:0] seq_pc;
  logic [31:0] br_pc;
  logic [31:0] addr;

  logic        wr;
  logic [4:0]  dest;
  logic [31:0] val;
  logic [31:0] npc;
  logic [1:0]  kind;
  logic [1:0]  size;
  logic [1:0]  fault;

  assign opc    = item_i.instr_word[31:26];
  assign fn     = item_i.instr_word[5:0];
  assign sh     = item_i.instr_word[10:6];
  assign rd_idx = item_i.instr_word[15:11];
  assign rt_idx = item_i.instr_word[20:16];
  assign imm    = item_i.instr_word[15:0];
  assign zimm   = {16'h0000, imm};
  assign simm   = {{16{imm[15]}}, imm};
  assign rs     = item_i.rs_value;
  assign rt     = item_i.rt_value;
  assign seq_pc = item_i.pc + 32'd4;
  assign br_pc  = seq_pc + {simm[29:0], 2'b00};
  assign addr   = rs + simm;

  always_comb begin
    wr    = 1'b0;
    dest  = 5'd0;
    val   = 32'h0;
    npc   = seq_pc;
    kind  = MemNone;
    size  = SizeByte;
    fault = FaultOk;

    if (item_i.pc[1:0] != 2'b00) begin
      fault = FaultPc;
    end else if (opc == OpSpecial) begin
      dest = rd_idx;
      wr   = 1'b1;
      case (fn)
        FnSll:  val = rt << sh;
        FnSrl:  val = rt >> sh;
        FnSra:  val = 32'($signed(rt) >>> sh);
        FnJr: begin
          wr   = 1'b0;
          dest = 5'd0;
          npc  = rs;
        end
        FnMfhi, FnMflo, FnMult, FnDiv, FnDivu: fault = FaultUnimp;
        FnAdd, FnAddu: val = rs + rt;
        FnSub, FnSubu: val = rs - rt;
        FnAnd:  val = rs & rt;
        FnOr:   val = rs | rt;
        FnNor:  val = ~(rs | rt);
        FnSlt:  val = {31'h0, $signed(rs) < $signed(rt)};
        FnSltu: val = {31'h0, rs < rt};
        default: fault = FaultUnknown;
      endcase
    end else begin
      dest = rt_idx;
      wr   = 1'b1;
      case (opc)
        OpJ, OpJal, OpCop0, OpCop1, OpLl, OpLd: fault = FaultUnimp;
        OpBeq: begin
          wr   = 1'b0;
          dest = 5'd0;
          if (rs == rt) npc = br_pc;
        end
        OpBne: begin
          wr   = 1'b0;
          dest = 5'd0;
          if (rs != rt) npc = br_pc;
        end
        OpAddi, OpAddiu: val = addr;
        OpSlti:  val = {31'h0, $signed(rs) < $signed(simm)};
        OpSltiu: val = {31'h0, rs < simm};
        OpAndi:  val = rs & zimm;
        OpOri:   val = rs | zimm;
        OpLui:   val = {imm, 16'h0000};
        OpLw: begin
          wr = 1'b0; kind = MemLoad; size = SizeWord;
        end
        OpLbu: begin
          wr = 1'b0; kind = MemLoad; size = SizeByte;
        end
        OpLhu: begin
          wr = 1'b0; kind = MemLoad; size = SizeHalf;
        end
        OpSb: begin
          wr = 1'b0; dest = 5'd0; kind = MemStore; size = SizeByte;
        end
        OpSh: begin
          wr = 1'b0; dest = 5'd0; kind = MemStore; size = SizeHalf;
        end
        OpSw: begin
          wr = 1'b0; dest = 5'd0; kind = MemStore; size = SizeWord;
        end
        default: fault = FaultUnknown;
      endcase
    end

    // any fault cancels the write and the memory request
    if (fault != FaultOk) begin
      wr   = 1'b0;
      dest = 5'd0;
      npc  = seq_pc;
      kind = MemNone;
      size = SizeByte;
    end
    if (dest == 5'd0) wr = 1'b0;
    if (!wr) val = 32'h0;
    if (!wr && kind != MemLoad) dest = 5'd0;
  end

  assign result_o.write_enable = wr;
  assign result_o.reg_index    = dest;
  assign result_o.write_value  = val;
  assign result_o.next_pc      = npc;
  assign result_o.mem_kind     = kind;
  assign result_o.mem_size     = size;
  assign result_o.mem_addr     = (kind != MemNone) ? addr : 32'h0;
  assign result_o.store_data   = (kind == MemStore) ? rt : 32'h0;
  assign result_o.fault        = fault;

endmodule

### rtl/risc_integer_execute_unit.sv
// top level: input register, decode and alu, result register
//
// integer execute stage for a 32-bit mips-style instruction set
// - input channel (in_valid_i / in_ready_o / in_item_i): one instruction
//   item with its pc and the two source register values
// - output channel (out_valid_o / out_ready_i / out_item_o): one result item
//   per instruction: register write, next pc, memory request and fault code
// - path: an accepted item sits in the input register, then the result
//   register loads its decode/alu result once it is free; decode and the
//   32-bit alu sit between the two registers
// - throughput: one item per cycle while out_ready_i stays high, set by
//   the single decode/alu pass
// - stall: when the receiver holds out_ready_i low the result register
//   keeps its item; the input register still takes one more item, then
//   in_ready_o drops until the result is taken
// - reset: both valid flags clear, no result is shown and the block is
//   ready for an item on the first cycle after reset
// - faults never stall: a faulting item gives its result like any other
module risc_integer_execute_unit
  import rieu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // input stage
  logic      in_valid_q;
  in_item_t  in_item_q;

  // result stage
  logic      out_valid_q;
  out_item_t out_item_q;

  out_item_t result;
  logic      out_free;   // result register can take a new item this cycle
  logic      in_free;    // input register can take a new item this cycle
  logic      in_valid_d;
  logic      out_valid_d;

  rieu_exec u_exec (
    .item_i   (in_item_q),
    .result_o (result)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign in_free  = !in_valid_q || out_free;

  // input register empties when its item moves on, refills on accept
  assign in_valid_d  = (in_valid_i && in_free) || (in_valid_q && !out_free);
  // result register refills from the input stage or empties when taken
  assign out_valid_d = out_free ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_free) begin
      in_item_q <= in_item_i;
    end
    if (out_free && in_valid_q) begin
      out_item_q <= result;
    end
  end

  assign in_ready_o  = in_free;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### rtl/rieu_checker.sv
// port checker for the execute unit and its bind
module rieu_checker
  import rieu_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a stalled result stays shown and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // input side only backs off while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with no waiting result");

  // faulting items carry no write and no memory request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.fault != FaultOk |->
      !out_item_o.write_enable && out_item_o.mem_kind == MemNone &&
      out_item_o.reg_index == 5'd0)
    else $error("fault with side effects");

  // register zero is never written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.write_enable |-> out_item_o.reg_index != 5'd0)
    else $error("write to register zero");

  // no memory request means empty address, size and store data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.mem_kind == MemNone |->
      out_item_o.mem_addr == 32'h0 && out_item_o.store_data == 32'h0 &&
      out_item_o.mem_size == SizeByte)
    else $error("memory fields set without a request");

endmodule

bind risc_integer_execute_unit rieu_checker u_rieu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
